// ===== rtl/c3zp_pkg.sv =====
`default_nettype none

package c3zp_pkg;

  // default line length
  localparam int MAX_WIDTH_DEF = 2048;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_KERNEL = 2'd2,
    REG_SHIFT  = 2'd3
  } cfg_idx_t;

  // register reset values
  localparam logic [11:0] WIDTH_RST  = 12'd640;
  localparam logic [11:0] HEIGHT_RST = 12'd480;
  localparam logic [62:0] KERNEL_RST = 63'd71499009379811200;
  localparam logic [2:0]  SHIFT_RST  = 3'd0;

  // queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef logic [7:0] pix_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       row_end;
    logic       frame_end;
  } out_item_t;

  // 3x3 neighbourhood, entry ky*3+kx, plus result flags
  typedef struct packed {
    pix_t [8:0] win;
    logic       row_end;
    logic       frame_end;
  } win_item_t;

endpackage

`default_nettype wire

// ===== rtl/conv3x3_zero_pad_stream_top.sv =====
// throughput: one beat per cycle, in and out, unless stalled, set by one line store read
// and one write a cycle; a result passes the slot, queue, product, sum and output registers
// reset: synchronous active-low; registers return to their defaults, then the
// line store is cleared one column a cycle from column 0 to MAX_WIDTH-1 with in_stall high
`default_nettype none

module conv3x3_zero_pad_stream_top #(
  parameter int MAX_WIDTH = c3zp_pkg::MAX_WIDTH_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  c3zp_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  wire                  out_stall,
  output c3zp_pkg::out_item_t  out_data,
  input  wire                  cfg_valid,
  output logic                 cfg_ready,
  input  wire [1:0]            cfg_index,
  input  wire [62:0]           cfg_data
);

  logic [11:0]                 width_r, height_r;
  logic [62:0]                 kernel_r;
  logic [2:0]                  shift_r;
  logic                        push_valid, q_valid, q_pop;
  c3zp_pkg::win_item_t         push_data, q_data;
  logic [c3zp_pkg::QCNT_W-1:0] q_count;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= c3zp_pkg::WIDTH_RST;
      height_r <= c3zp_pkg::HEIGHT_RST;
      kernel_r <= c3zp_pkg::KERNEL_RST;
      shift_r  <= c3zp_pkg::SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (c3zp_pkg::cfg_idx_t'(cfg_index))
        c3zp_pkg::REG_WIDTH:  width_r  <= cfg_data[11:0];
        c3zp_pkg::REG_HEIGHT: height_r <= cfg_data[11:0];
        c3zp_pkg::REG_KERNEL: kernel_r <= cfg_data;
        c3zp_pkg::REG_SHIFT:  shift_r  <= cfg_data[2:0];
      endcase
    end
  end

  c3zp_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .image_width  (width_r),
    .image_height (height_r),
    .q_count      (q_count),
    .push_valid   (push_valid),
    .push_data    (push_data)
  );

  c3zp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data),
    .count      (q_count)
  );

  c3zp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .kernel_coeffs (kernel_r),
    .result_shift  (shift_r),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/c3zp_front.sv =====
`default_nettype none

module c3zp_front #(
  parameter int MAX_WIDTH = c3zp_pkg::MAX_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  c3zp_pkg::in_item_t            in_data,
  input  wire [11:0]                    image_width,
  input  wire [11:0]                    image_height,
  input  wire [c3zp_pkg::QCNT_W-1:0]    q_count,
  output logic                          push_valid,
  output c3zp_pkg::win_item_t           push_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_WIDTH - 1);

  typedef struct packed {
    logic [AW-1:0]   addr;
    c3zp_pkg::pix_t  pix;
    logic            first;
    logic            lo_ok;
    logic            up_ok;
    logic            emit;
    logic            row_end;
    logic            frame_end;
  } slot_t;

  logic [AW-1:0]   col_r, col_nxt;
  logic [12:0]     row_r, row_nxt;
  logic            clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]   clr_addr_r, clr_addr_nxt;
  logic            s1_valid_r;
  slot_t           s1_r, s1_nxt;
  c3zp_pkg::pix_t [8:0] win_r, win_nxt, win_out;

  logic [WW-1:0]   w_eff;
  logic [11:0]     h_eff;
  logic [12:0]     h1;
  logic [AW-1:0]   c;
  logic [12:0]     r;
  logic [WW-1:0]   c_inc;
  logic            accept;

  logic [15:0]     mem [MAX_WIDTH];
  logic [15:0]     rd_q;
  logic            byp_r;
  logic [15:0]     byp_d_r;
  logic            wen;
  logic [AW-1:0]   waddr;
  logic [15:0]     wdata;
  logic [15:0]     rdv;
  c3zp_pkg::pix_t  up_m, lo_m;
  c3zp_pkg::pix_t [2:0] colv;

  // effective geometry
  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = WW'(1);
    end else if (WW'(image_width) > MAXW) begin
      w_eff = MAXW;
    end else begin
      w_eff = WW'(image_width);
    end
    h_eff = (image_height == 12'd0) ? 12'd1 : image_height;
    h1    = {1'b0, h_eff} + 13'd1;
  end

  // slot position with wrap after geometry change
  always_comb begin
    c     = (WW'(col_r) >= w_eff) ? '0 : col_r;
    r     = (row_r > h1) ? 13'd0 : row_r;
    c_inc = WW'(c) + WW'(1);
    if (c_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = r + 13'd1;
    end else begin
      col_nxt = c_inc[AW-1:0];
      row_nxt = r;
    end
    if (r >= h1) begin
      col_nxt = '0;
      row_nxt = 13'd0;
    end
  end

  // input stall: clearing pass or no room downstream
  assign in_stall = clr_busy_r ||
                    ((c3zp_pkg::QCNT_W + 1)'(q_count) + (c3zp_pkg::QCNT_W + 1)'(s1_valid_r)
                     >= (c3zp_pkg::QCNT_W + 1)'(c3zp_pkg::QDEPTH));
  assign accept = in_valid && !in_stall;

  // classify the slot
  always_comb begin
    s1_nxt.addr      = c;
    s1_nxt.pix       = (in_data.kind || (r >= {1'b0, h_eff})) ? 8'd0 : in_data.pixel_in;
    s1_nxt.first     = (c == '0);
    s1_nxt.lo_ok     = (r >= 13'd1);
    s1_nxt.up_ok     = (r >= 13'd2);
    s1_nxt.emit      = (c == '0) ? (r >= 13'd2) : ((r >= 13'd1) && (r <= {1'b0, h_eff}));
    s1_nxt.row_end   = (c == '0);
    s1_nxt.frame_end = (c == '0) && (r == h1);
  end

  // clearing pass over the line store
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      s1_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  // line store: {upper, lower} per column
  assign wen   = clr_busy_r || s1_valid_r;
  assign waddr = clr_busy_r ? clr_addr_r : s1_r.addr;
  assign wdata = clr_busy_r ? 16'd0 : {rdv[7:0], s1_r.pix};

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rd_q    <= mem[c];
    byp_r   <= wen && (waddr == c);
    byp_d_r <= wdata;
  end

  assign rdv  = byp_r ? byp_d_r : rd_q;
  assign up_m = s1_r.up_ok ? rdv[15:8] : 8'd0;
  assign lo_m = s1_r.lo_ok ? rdv[7:0] : 8'd0;

  // window shift and result window
  always_comb begin
    colv[0] = up_m;
    colv[1] = lo_m;
    colv[2] = s1_r.pix;
    for (int i = 0; i < 3; i++) begin
      if (s1_r.first) begin
        win_out[i*3+0] = win_r[i*3+1];
        win_out[i*3+1] = win_r[i*3+2];
        win_out[i*3+2] = 8'd0;
        win_nxt[i*3+0] = 8'd0;
        win_nxt[i*3+1] = 8'd0;
        win_nxt[i*3+2] = colv[i];
      end else begin
        win_nxt[i*3+0] = win_r[i*3+1];
        win_nxt[i*3+1] = win_r[i*3+2];
        win_nxt[i*3+2] = colv[i];
        win_out[i*3+0] = win_nxt[i*3+0];
        win_out[i*3+1] = win_nxt[i*3+1];
        win_out[i*3+2] = win_nxt[i*3+2];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (s1_valid_r) begin
      win_r <= win_nxt;
    end
  end

  // hand the window to the queue
  assign push_valid          = s1_valid_r && s1_r.emit;
  assign push_data.win       = win_out;
  assign push_data.row_end   = s1_r.row_end;
  assign push_data.frame_end = s1_r.frame_end;

endmodule

`default_nettype wire

// ===== rtl/c3zp_fifo.sv =====
`default_nettype none

module c3zp_fifo (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         push_valid,
  input  c3zp_pkg::win_item_t         push_data,
  input  wire                         pop,
  output logic                        pop_valid,
  output c3zp_pkg::win_item_t         pop_data,
  output logic [c3zp_pkg::QCNT_W-1:0] count
);

  c3zp_pkg::win_item_t                 slots_r [c3zp_pkg::QDEPTH];
  logic [c3zp_pkg::QPTR_W-1:0]         wr_ptr_r, rd_ptr_r;
  logic [c3zp_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;
  logic                                do_pop;

  assign pop_valid = (cnt_r != '0);
  assign pop_data  = slots_r[rd_ptr_r];
  assign do_pop    = pop && pop_valid;
  assign count     = cnt_r;

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (push_valid && !do_pop) begin
      cnt_nxt = cnt_r + c3zp_pkg::QCNT_W'(1);
    end else if (!push_valid && do_pop) begin
      cnt_nxt = cnt_r - c3zp_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push_valid) begin
        wr_ptr_r <= wr_ptr_r + c3zp_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + c3zp_pkg::QPTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_valid) begin
      slots_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/c3zp_back.sv =====
`default_nettype none

module c3zp_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire [62:0]           kernel_coeffs,
  input  wire [2:0]            result_shift,
  input  wire                  q_valid,
  input  c3zp_pkg::win_item_t  q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output c3zp_pkg::out_item_t  out_data
);

  logic                    adv;
  logic                    a_valid_r, b_valid_r, out_valid_r;
  logic signed [15:0]      a_prod_r [9];
  logic signed [15:0]      prod [9];
  logic                    a_re_r, a_fe_r, b_re_r, b_fe_r;
  logic signed [19:0]      b_sum_r, sum;
  c3zp_pkg::out_item_t     out_data_r;
  logic [7:0]              pix_q;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && q_valid;

  // nine products
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      prod[i] = $signed({1'b0, q_data.win[i]}) * $signed(kernel_coeffs[7*i +: 7]);
    end
  end

  // adder tree
  always_comb begin
    sum = '0;
    for (int i = 0; i < 9; i++) begin
      sum = sum + 20'(a_prod_r[i]);
    end
  end

  // round half to even, then saturate
  always_comb begin
    logic [18:0] s;
    logic [18:0] q;
    logic [18:0] rem;
    logic [18:0] half;
    s    = b_sum_r[18:0];
    q    = s >> result_shift;
    rem  = s & ((19'd1 << result_shift) - 19'd1);
    half = 19'd1 << (result_shift - 3'd1);
    if ((result_shift != 3'd0) && ((rem > half) || ((rem == half) && q[0]))) begin
      q = q + 19'd1;
    end
    if (b_sum_r <= 20'sd0) begin
      pix_q = 8'd0;
    end else if (q > 19'd255) begin
      pix_q = 8'd255;
    end else begin
      pix_q = q[7:0];
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= q_valid;
      b_valid_r   <= a_valid_r;
      out_valid_r <= b_valid_r;
    end
  end

  // data stages
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) begin
        a_prod_r[i] <= prod[i];
      end
      a_re_r               <= q_data.row_end;
      a_fe_r               <= q_data.frame_end;
      b_sum_r              <= sum;
      b_re_r               <= a_re_r;
      b_fe_r               <= a_fe_r;
      out_data_r.pixel_out <= pix_q;
      out_data_r.row_end   <= b_re_r;
      out_data_r.frame_end <= b_fe_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== rtl/c3zp_checker.sv =====
`default_nettype none

module c3zp_checker (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 in_stall,
  input wire                 out_valid,
  input wire                 out_stall,
  input c3zp_pkg::out_item_t out_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // end of frame is always end of row
  a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.frame_end || out_data.row_end))
    else $error("frame end without row end");

  // line store clearing holds off input after reset
  a_clear_stall: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input taken during clearing");

  // no result right after reset
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind conv3x3_zero_pad_stream_top c3zp_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ===== tb/sv/tb_conv3x3_zero_pad_stream_top.sv =====
`default_nettype none

module tb_conv3x3_zero_pad_stream_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_MAX    = 2048;
  localparam int ITEM_TARGET = 880;
  localparam int SETTLE_CYC  = 20;
  localparam int CYCLE_LIMIT = 3000000;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  c3zp_pkg::in_item_t   in_data;
  logic                 out_valid;
  logic                 out_stall;
  c3zp_pkg::out_item_t  out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [62:0]          cfg_data;

  conv3x3_zero_pad_stream_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // shadow registers and filter state
  logic [11:0]                sh_width;
  logic [11:0]                sh_height;
  logic [62:0]                sh_kernel;
  logic [2:0]                 sh_shift;
  c3zp_pkg::pix_t             upper_row [LINE_MAX];
  c3zp_pkg::pix_t             lower_row [LINE_MAX];
  c3zp_pkg::pix_t [8:0]       nbhd;
  int unsigned                col_pos;
  int unsigned                row_pos;

  c3zp_pkg::out_item_t        pending_pixels [$];
  c3zp_pkg::out_item_t        head_pixel;
  int          errors;
  int          n_items;
  int          cycle_cnt;
  int          in_mode;
  int          out_mode;

  typedef struct {
    bit                  kind;
    c3zp_pkg::pix_t      pix;
    bit                  typed;
    bit                  hit;
    c3zp_pkg::out_item_t res;
  } dir_row_t;

  dir_row_t dir_rows [20];

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // weighted sum, shift, round half to even, saturate
  function automatic c3zp_pkg::pix_t filter_sum(c3zp_pkg::pix_t [8:0] wv);
    int                 sum;
    int unsigned        s;
    int unsigned        q;
    int unsigned        rem;
    int unsigned        half;
    logic signed [6:0]  k;
    sum = 0;
    for (int i = 0; i < 9; i++) begin
      k = sh_kernel[7*i +: 7];
      sum += int'(k) * int'(wv[i]);
    end
    if (sum <= 0) return 8'd0;
    s = sum;
    q = s >> sh_shift;
    if (sh_shift > 0) begin
      rem  = s & ((32'd1 << sh_shift) - 1);
      half = 32'd1 << (sh_shift - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  // advance the filter by one slot
  task automatic filter_step(input c3zp_pkg::in_item_t it, output bit got,
                             output c3zp_pkg::out_item_t res);
    int unsigned          w;
    int unsigned          h;
    int unsigned          c;
    int unsigned          r;
    c3zp_pkg::pix_t       p;
    c3zp_pkg::pix_t       up;
    c3zp_pkg::pix_t       lo;
    c3zp_pkg::pix_t [8:0] tmp;
    got = 1'b0;
    res = '0;
    w = (sh_width == 0) ? 1 : ((sh_width > LINE_MAX) ? LINE_MAX : sh_width);
    h = (sh_height == 0) ? 1 : sh_height;
    if (col_pos >= w) col_pos = 0;
    if (row_pos > h + 1) row_pos = 0;
    c = col_pos;
    r = row_pos;
    p = (it.kind || r >= h) ? 8'd0 : it.pixel_in;
    up = upper_row[c];
    lo = lower_row[c];
    upper_row[c] = lo;
    lower_row[c] = p;
    if (r < 2) up = 8'd0;
    if (r < 1) lo = 8'd0;
    if (c == 0) begin
      // last pixel of an earlier row, right side padded
      if (r >= 2 && r - 2 < h) begin
        for (int i = 0; i < 3; i++) begin
          tmp[i*3]   = nbhd[i*3+1];
          tmp[i*3+1] = nbhd[i*3+2];
          tmp[i*3+2] = 8'd0;
        end
        res.pixel_out = filter_sum(tmp);
        res.row_end   = 1'b1;
        res.frame_end = (r - 2 == h - 1);
        got = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
        nbhd[i*3]   = 8'd0;
        nbhd[i*3+1] = 8'd0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        nbhd[i*3]   = nbhd[i*3+1];
        nbhd[i*3+1] = nbhd[i*3+2];
      end
    end
    nbhd[2] = up;
    nbhd[5] = lo;
    nbhd[8] = p;
    if (c != 0 && r >= 1 && r - 1 < h) begin
      res.pixel_out = filter_sum(nbhd);
      got = 1'b1;
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (row_pos >= h + 1) begin
      c = 0;
      r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // gap length: mostly short, a few long
  function automatic int pick_gap(int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // write all four registers, valid held across beats
  task automatic configure(input logic [11:0] w, input logic [11:0] h,
                           input logic [62:0] k, input logic [2:0] s);
    logic [62:0] vals [4];
    vals[0] = 63'(w);
    vals[1] = 63'(h);
    vals[2] = k;
    vals[3] = 63'(s);
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= i[1:0];
      cfg_data  <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (c3zp_pkg::cfg_idx_t'(i[1:0]))
        c3zp_pkg::REG_WIDTH:  sh_width  = vals[i][11:0];
        c3zp_pkg::REG_HEIGHT: sh_height = vals[i][11:0];
        c3zp_pkg::REG_KERNEL: sh_kernel = vals[i];
        c3zp_pkg::REG_SHIFT:  sh_shift  = vals[i][2:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // one input beat, then an optional gap
  task automatic send_item(input c3zp_pkg::in_item_t it, input bit typed, input bit hit,
                           input c3zp_pkg::out_item_t typed_res);
    bit                  got;
    c3zp_pkg::out_item_t res;
    int                  n;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
    filter_step(it, got, res);
    if (typed) begin
      if (hit) pending_pixels.push_back(typed_res);
    end else if (got) begin
      pending_pixels.push_back(res);
    end
    n = pick_gap(in_mode);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // frame of pixels plus drain beats, with optional noise and truncation
  task automatic send_frame(input int noise, input bit broken);
    int unsigned        w;
    int unsigned        h;
    int unsigned        total;
    int unsigned        stop;
    int                 r;
    c3zp_pkg::in_item_t it;
    w = (sh_width == 0) ? 1 : ((sh_width > LINE_MAX) ? LINE_MAX : sh_width);
    h = (sh_height == 0) ? 1 : sh_height;
    total = w * h;
    stop = $urandom_range(0, total + w);
    for (int unsigned i = 0; i < total + w + 1; i++) begin
      if (broken && i == stop) break;
      it.kind = (i >= total);
      if ($urandom_range(0, 99) < noise) it.kind = ~it.kind;
      r = $urandom_range(0, 9);
      it.pixel_in = (r == 0) ? 8'd0 : ((r == 1) ? 8'd255 : 8'($urandom));
      send_item(it, 1'b0, 1'b0, '0);
    end
  endtask

  // stop sending and let the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // receiver stall pattern
  initial begin
    int n;
    forever begin
      @(posedge clk);
      n = pick_gap(out_mode);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // result check against oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected result beat pixel_out=%0d", out_data.pixel_out);
        errors++;
      end else begin
        head_pixel = pending_pixels.pop_front();
        if (out_data.pixel_out !== head_pixel.pixel_out) begin
          $error("pixel_out expected %0d actual %0d", head_pixel.pixel_out, out_data.pixel_out);
          errors++;
        end
        if (out_data.row_end !== head_pixel.row_end) begin
          $error("row_end expected %0d actual %0d", head_pixel.row_end, out_data.row_end);
          errors++;
        end
        if (out_data.frame_end !== head_pixel.frame_end) begin
          $error("frame_end expected %0d actual %0d", head_pixel.frame_end, out_data.frame_end);
          errors++;
        end
      end
    end
  end

  // main sequence
  initial begin
    c3zp_pkg::in_item_t it;
    int                 noise;
    int                 r;
    logic [11:0]        w;
    logic [11:0]        h;
    logic [62:0]        k;

    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    errors    = 0;
    n_items   = 0;
    cycle_cnt = 0;
    in_mode   = 1;
    out_mode  = 1;
    sh_width  = c3zp_pkg::WIDTH_RST;
    sh_height = c3zp_pkg::HEIGHT_RST;
    sh_kernel = c3zp_pkg::KERNEL_RST;
    sh_shift  = c3zp_pkg::SHIFT_RST;
    nbhd      = '0;
    col_pos   = 0;
    row_pos   = 0;
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_row[i] = 8'd0;
      lower_row[i] = 8'd0;
    end

    // 3x2 frame of 255: every output is 255, lag of width+1 slots
    for (int i = 0; i < 10; i++) begin
      dir_rows[i].kind  = (i >= 6);
      dir_rows[i].pix   = 8'd255;
      dir_rows[i].typed = 1'b1;
      dir_rows[i].hit   = (i >= 4);
      dir_rows[i].res   = '{pixel_out: 8'd255, row_end: (i == 6 || i == 9),
                            frame_end: (i == 9)};
    end
    // checkerboard with a drain inside the frame, negative sums
    for (int i = 10; i < 20; i++) begin
      dir_rows[i].kind  = (i == 14 || i >= 16);
      dir_rows[i].pix   = (i % 2 == 0) ? 8'd255 : 8'd0;
      dir_rows[i].typed = 1'b0;
      dir_rows[i].hit   = 1'b0;
      dir_rows[i].res   = '0;
    end

    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed part
    configure(12'd3, 12'd2, c3zp_pkg::KERNEL_RST, 3'd0);
    for (int i = 0; i < 20; i++) begin
      it.kind     = dir_rows[i].kind;
      it.pixel_in = dir_rows[i].pix;
      send_item(it, dir_rows[i].typed, dir_rows[i].hit, dir_rows[i].res);
    end
    wait_idle();

    // random phases
    while (n_items < ITEM_TARGET) begin
      r = $urandom_range(0, 19);
      w = (r < 14) ? 12'($urandom_range(1, 6))
                   : ((r < 18) ? 12'($urandom_range(7, 40)) : 12'($urandom_range(0, 1)));
      h = ($urandom_range(0, 9) == 0) ? 12'd0 : 12'($urandom_range(1, 6));
      k = ($urandom_range(0, 9) < 3) ? c3zp_pkg::KERNEL_RST : 63'({$urandom, $urandom});
      configure(w, h, k, 3'($urandom_range(0, 7)));
      in_mode  = ($urandom_range(0, 3) == 0) ? 0 : 1;
      out_mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
      noise = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(5, 20);
      for (int f = $urandom_range(1, 3); f > 0; f--)
        send_frame(noise, $urandom_range(0, 99) < 15);
      wait_idle();
    end

    // wide line, largest coefficients
    in_mode  = 1;
    out_mode = 1;
    configure(12'd60, 12'd1, {9{7'h3f}}, 3'd7);
    send_frame(0, 1'b0);
    wait_idle();
    // tall frame, most negative coefficients
    configure(12'd1, 12'd40, {9{7'h40}}, 3'd0);
    send_frame(0, 1'b0);
    wait_idle();
    // zero width and height
    configure(12'd0, 12'd0, 63'({$urandom, $urandom}), 3'd3);
    send_frame(10, 1'b0);
    wait_idle();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
